/* src/aesbe_pkg.sv */
// Shared types, register indexes and AES byte functions for the AES block encrypt unit.
// Used by aesbe_key_exp, aesbe_round and aes_block_encrypt_unit. No dependencies.
package aesbe_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;

   // Key length codes
   localparam logic [1:0] KEY_LEN_128 = 2'd0;
   localparam logic [1:0] KEY_LEN_192 = 2'd1;
   localparam logic [1:0] KEY_LEN_256 = 2'd2;
   localparam logic [1:0] KEY_LEN_RSV = 2'd3;

   localparam int NUM_STAGES = 15;

   // Round keys 0..14, key 0 is the initial whitening key
   typedef logic [NUM_STAGES-1:0][127:0] rkey_set_type;

   // Operation of one pipeline stage
   typedef enum logic [1:0] {
      RND_ADDKEY = 2'd0,
      RND_FULL   = 2'd1,
      RND_LAST   = 2'd2,
      RND_PASS   = 2'd3
   } rnd_mode_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] sub_byte(input logic [7:0] v);
      return SBOX[v];
   endfunction

   // Multiply by x in GF(2^8)
   function automatic logic [7:0] gmul2(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
   endfunction

   // SubBytes and ShiftRows, then MixColumns unless last; byte 0 in bits 127:120
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [127:0] t;
      logic [127:0] m;
      logic [7:0]   a0, a1, a2, a3, all;
      t = '0;
      m = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = sub_byte(s[127-8*(4*((c+r)%4)+r) -: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0  = t[127-32*c -: 8];
         a1  = t[119-32*c -: 8];
         a2  = t[111-32*c -: 8];
         a3  = t[103-32*c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         m[127-32*c -: 8] = a0 ^ all ^ gmul2(a0 ^ a1);
         m[119-32*c -: 8] = a1 ^ all ^ gmul2(a1 ^ a2);
         m[111-32*c -: 8] = a2 ^ all ^ gmul2(a2 ^ a3);
         m[103-32*c -: 8] = a3 ^ all ^ gmul2(a3 ^ a0);
      end
      return last ? t : m;
   endfunction

endpackage

/* src/aesbe_key_exp.sv */
// Sequential AES key expansion: one schedule word per cycle into a round key register file.
// Depends on aesbe_pkg.
module aesbe_key_exp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic [1:0]             key_len,
   input  logic [3:0][63:0]       key_words,
   output logic                   busy,
   output aesbe_pkg::rkey_set_type round_keys
);

   typedef enum logic [2:0] {
      KX_LOAD = 3'b001,
      KX_RUN  = 3'b010,
      KX_DONE = 3'b100
   } kx_state_type;

   kx_state_type       state_ff, state_in;
   logic [59:0][31:0]  sched_ff;
   logic [7:0][31:0]   window_ff, window_in;
   logic [5:0]         idx_ff, idx_in;
   logic [2:0]         pos_ff, pos_in;
   logic [7:0]         rcon_ff, rcon_in;
   logic [7:0][31:0]   kwords;
   logic [3:0]         nk;
   logic [3:0]         offset;
   logic [5:0]         last_idx;
   logic [2:0]         back_sel;
   logic [31:0]        temp;
   logic [31:0]        new_word;

   // Split the key registers into 32-bit words, word 0 first
   for (genvar k = 0; k < 8; k++) begin : g_kw
      assign kwords[k] = (k % 2 == 0) ? key_words[k/2][63:32] : key_words[k/2][31:0];
   end

   // Gather schedule words into 128-bit round keys
   for (genvar r = 0; r < aesbe_pkg::NUM_STAGES; r++) begin : g_rk
      assign round_keys[r] = {sched_ff[4*r], sched_ff[4*r+1], sched_ff[4*r+2], sched_ff[4*r+3]};
   end

   assign nk       = 4'd4 + {1'b0, key_len, 1'b0};
   assign offset   = 4'd8 - nk;
   assign last_idx = {nk, 2'b00} + 6'd27;
   assign back_sel = offset[2:0];
   assign busy     = (state_ff != KX_DONE);

   // Next schedule word from the sliding window of the last eight words
   always_comb begin
      temp = window_ff[7];
      if (pos_ff == 3'd0) begin
         temp = aesbe_pkg::sub_word({temp[23:0], temp[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (key_len == aesbe_pkg::KEY_LEN_256 && pos_ff == 3'd4) begin
         temp = aesbe_pkg::sub_word(temp);
      end
      new_word = window_ff[back_sel] ^ temp;
   end

   // Sequencer control
   always_comb begin
      state_in  = state_ff;
      window_in = window_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      rcon_in   = rcon_ff;
      unique case (state_ff)
         KX_LOAD: begin
            for (int j = 0; j < 8; j++) begin
               window_in[j] = (4'(j) >= offset) ? kwords[3'(4'(j) - offset)] : '0;
            end
            idx_in   = {2'b00, nk};
            pos_in   = 3'd0;
            rcon_in  = 8'h01;
            state_in = KX_RUN;
         end
         KX_RUN: begin
            for (int j = 0; j < 7; j++) begin
               window_in[j] = window_ff[j+1];
            end
            window_in[7] = new_word;
            idx_in = idx_ff + 6'd1;
            pos_in = (pos_ff == 3'(nk - 4'd1)) ? 3'd0 : pos_ff + 3'd1;
            if (pos_ff == 3'd0) begin
               rcon_in = aesbe_pkg::gmul2(rcon_ff);
            end
            if (idx_ff == last_idx) begin
               state_in = KX_DONE;
            end
         end
         KX_DONE: begin
            state_in = KX_DONE;
         end
         default: begin
            state_in = KX_LOAD;
         end
      endcase
      if (restart) begin
         state_in = KX_LOAD;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KX_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the window and write the schedule
   always_ff @(posedge clock) begin
      window_ff <= window_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      rcon_ff   <= rcon_in;
      if (state_ff == KX_LOAD) begin
         for (int k = 0; k < 8; k++) begin
            sched_ff[k] <= kwords[k];
         end
      end else if (state_ff == KX_RUN) begin
         sched_ff[idx_ff] <= new_word;
      end
   end

endmodule

/* src/aesbe_round.sv */
// One pipeline stage of the cipher: a round, last round, key add or pass, and its register.
// Depends on aesbe_pkg.
module aesbe_round (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [127:0]            in_data,
   input  logic [127:0]            round_key,
   input  aesbe_pkg::rnd_mode_type mode,
   output logic                    out_valid,
   output logic [127:0]            out_data
);

   logic         valid_ff;
   logic [127:0] data_ff, data_in;

   // Stage function
   always_comb begin
      unique case (mode)
         aesbe_pkg::RND_ADDKEY: data_in = in_data ^ round_key;
         aesbe_pkg::RND_FULL:   data_in = aesbe_pkg::aes_round(in_data, 1'b0) ^ round_key;
         aesbe_pkg::RND_LAST:   data_in = aesbe_pkg::aes_round(in_data, 1'b1) ^ round_key;
         aesbe_pkg::RND_PASS:   data_in = in_data;
         default:               data_in = in_data;
      endcase
   end

   // Advance valid with the data, hold otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/aes_block_encrypt_unit.sv */
// AES-128/192/256 encryption: key registers, key expansion unit and 15-stage round pipeline.
// Depends on aesbe_pkg, aesbe_key_exp and aesbe_round.
//
// The unit takes one 128-bit plaintext block per cycle while req_stall is low and returns its
// ciphertext from the last stage: one pipeline stage for the initial key add and one per round,
// 14 in all; shorter keys pass through the unused round stages, so every key length takes the
// same path. Each stage advances on its own when the stage after it has room, so bubbles close
// up and the input keeps flowing while a finished block waits at the output, until the pipeline
// fills. After reset and after any configuration write the key expansion unit rebuilds the round
// keys one word per cycle and req_stall stays high meanwhile.
module aes_block_encrypt_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int LastStage = aesbe_pkg::NUM_STAGES - 1;

   logic [1:0]                     key_length_ff;
   logic [3:0][63:0]               key_word_ff;
   logic [1:0]                     key_len;
   logic [3:0]                     num_rounds;
   logic                           key_busy;
   aesbe_pkg::rkey_set_type        round_keys;
   logic [LastStage:0]             stage_valid;
   logic [LastStage:0][127:0]      stage_data;
   logic [LastStage:0]             stage_adv;
   aesbe_pkg::rnd_mode_type        stage_mode [aesbe_pkg::NUM_STAGES];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= aesbe_pkg::KEY_LEN_128;
         key_word_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            aesbe_pkg::CSR_KEY_LENGTH: key_length_ff  <= csr_wdata[1:0];
            aesbe_pkg::CSR_KEY_WORD_0: key_word_ff[0] <= csr_wdata;
            aesbe_pkg::CSR_KEY_WORD_1: key_word_ff[1] <= csr_wdata;
            aesbe_pkg::CSR_KEY_WORD_2: key_word_ff[2] <= csr_wdata;
            aesbe_pkg::CSR_KEY_WORD_3: key_word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Reserved length code runs as a 256-bit key
   assign key_len    = (key_length_ff == aesbe_pkg::KEY_LEN_RSV) ? aesbe_pkg::KEY_LEN_256
                                                                  : key_length_ff;
   assign num_rounds = 4'd10 + {1'b0, key_len, 1'b0};

   aesbe_key_exp u_key_exp (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_wr_en),
      .key_len    (key_len),
      .key_words  (key_word_ff),
      .busy       (key_busy),
      .round_keys (round_keys)
   );

   // Stage operation from the round count
   always_comb begin
      stage_mode[0] = aesbe_pkg::RND_ADDKEY;
      for (int k = 1; k <= LastStage; k++) begin
         if (4'(k) < num_rounds) begin
            stage_mode[k] = aesbe_pkg::RND_FULL;
         end else if (4'(k) == num_rounds) begin
            stage_mode[k] = aesbe_pkg::RND_LAST;
         end else begin
            stage_mode[k] = aesbe_pkg::RND_PASS;
         end
      end
   end

   // A stage advances when it is empty or the next one advances
   always_comb begin
      stage_adv[LastStage] = !stage_valid[LastStage] || !rsp_stall;
      for (int k = LastStage - 1; k >= 0; k--) begin
         stage_adv[k] = !stage_valid[k] || stage_adv[k+1];
      end
   end

   assign req_stall = key_busy || !stage_adv[0];

   for (genvar k = 0; k <= LastStage; k++) begin : g_stage
      if (k == 0) begin : g_first
         aesbe_round u_round (
            .clock     (clock),
            .reset     (reset),
            .advance   (stage_adv[0]),
            .in_valid  (req_valid && !req_stall),
            .in_data   ({req_plain_high, req_plain_low}),
            .round_key (round_keys[0]),
            .mode      (stage_mode[0]),
            .out_valid (stage_valid[0]),
            .out_data  (stage_data[0])
         );
      end else begin : g_next
         aesbe_round u_round (
            .clock     (clock),
            .reset     (reset),
            .advance   (stage_adv[k]),
            .in_valid  (stage_valid[k-1]),
            .in_data   (stage_data[k-1]),
            .round_key (round_keys[k]),
            .mode      (stage_mode[k]),
            .out_valid (stage_valid[k]),
            .out_data  (stage_data[k])
         );
      end
   end

   assign rsp_valid       = stage_valid[LastStage];
   assign rsp_cipher_high = stage_data[LastStage][127:64];
   assign rsp_cipher_low  = stage_data[LastStage][63:0];

   // No block enters while round keys are being rebuilt
   assert property (@(posedge clock) csr_wr_en |=> req_stall)
      else $error("block accepted right after a key register write");

   assert property (@(posedge clock) reset |=> req_stall)
      else $error("block accepted before key expansion after reset");

   // A full pipeline under output stall keeps its blocks
   assert property (@(posedge clock) disable iff (reset)
      stage_valid[LastStage-1] && stage_valid[LastStage] && rsp_stall
      |=> stage_valid[LastStage-1] && stage_valid[LastStage])
      else $error("block dropped from a stalled pipeline");

   // An accepted request must load a valid block into stage 0
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> stage_valid[0])
      else $error("transfer lost at pipeline entry");

endmodule

/* sim/tb_aes_block_encrypt_unit.sv */
// Testbench for aes_block_encrypt_unit: random AES-128/192/256 encryption with a self-checking
// cipher predictor. Depends on aesbe_pkg and the RTL of aes_block_encrypt_unit.
`timescale 1ns / 1ps

module tb_aes_block_encrypt_unit;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_plain_high = '0;
   logic [63:0] req_plain_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   block_type   plain_q[$];
   block_type   cipher_q[$];
   logic [1:0]  key_len_q = aesbe_pkg::KEY_LEN_128;
   logic [63:0] key_q[4] = '{default: '0};
   int          errors = 0;
   bit          quiet = 0;
   int          req_gap = 0;
   int          rsp_hold = 0;

   // High while the held request has not yet transferred
   logic        req_stall_seen = 1'b0;

   aes_block_encrypt_unit i_dut (.*);

   always #2 clock = ~clock;

   // Multiply by x in GF(2^8)
   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] v);
      return {aesbe_pkg::SBOX[v[31:24]], aesbe_pkg::SBOX[v[23:16]],
              aesbe_pkg::SBOX[v[15:8]], aesbe_pkg::SBOX[v[7:0]]};
   endfunction

   // Encrypt one block under the current key registers
   function automatic logic [127:0] aes_cipher(input logic [127:0] pt);
      logic [31:0]  w[60];
      logic [31:0]  tmp;
      logic [7:0]   rc;
      logic [7:0]   a0, a1, a2, a3;
      logic [127:0] s, t;
      logic [1:0]   code;
      int           nk, nr;
      code = (key_len_q == aesbe_pkg::KEY_LEN_RSV) ? aesbe_pkg::KEY_LEN_256 : key_len_q;
      nk = 4 + 2 * code;
      nr = nk + 6;
      for (int i = 0; i < nk; i++)
         w[i] = i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
      rc = 8'h01;
      for (int i = nk; i < 4 * (nr + 1); i++) begin
         tmp = w[i-1];
         if (i % nk == 0) begin
            tmp = sbox_word({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
            rc = xt(rc);
         end else if (nk == 8 && i % nk == 4) begin
            tmp = sbox_word(tmp);
         end
         w[i] = w[i-nk] ^ tmp;
      end
      s = pt ^ {w[0], w[1], w[2], w[3]};
      for (int rd = 1; rd <= nr; rd++) begin
         // substitute and rotate rows
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[127-8*(4*c+r) -: 8] = aesbe_pkg::SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
         // mix columns except in the final round
         if (rd < nr) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[127-32*c -: 8];
               a1 = t[119-32*c -: 8];
               a2 = t[111-32*c -: 8];
               a3 = t[103-32*c -: 8];
               t[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
               t[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
               t[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
               t[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
         end
         s = t ^ {w[4*rd], w[4*rd+1], w[4*rd+2], w[4*rd+3]};
      end
      return s;
   endfunction

   // Write one register while the block is idle and track it locally
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == aesbe_pkg::CSR_KEY_LENGTH)
         key_len_q = data[1:0];
      else if (idx >= aesbe_pkg::CSR_KEY_WORD_0 && idx <= aesbe_pkg::CSR_KEY_WORD_3)
         key_q[idx - aesbe_pkg::CSR_KEY_WORD_0] = data;
   endtask

   function automatic logic [63:0] rnd64();
      unique case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Drive the request side: advance only when nothing is held or the held item transferred
   always @(negedge clock) begin
      if (!reset && (!req_valid || !req_stall_seen)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (plain_q.size() > 0) begin
            block_type b;
            b = plain_q.pop_front();
            req_valid      <= 1'b1;
            req_plain_high <= b.hi;
            req_plain_low  <= b.lo;
            if (!quiet && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side in bursts
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(1, 9) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      block_type    e;
      logic [127:0] ct;
      req_stall_seen <= req_valid && req_stall;
      if (!reset && req_valid && !req_stall) begin
         ct = aes_cipher({req_plain_high, req_plain_low});
         e.hi = ct[127:64];
         e.lo = ct[63:0];
         cipher_q.push_back(e);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h %h", $time, rsp_cipher_high, rsp_cipher_low);
         end else begin
            e = cipher_q.pop_front();
            if (rsp_cipher_high !== e.hi) begin
               errors++;
               $display("%0t: cipher_high expected %h actual %h", $time, e.hi, rsp_cipher_high);
            end
            if (rsp_cipher_low !== e.lo) begin
               errors++;
               $display("%0t: cipher_low expected %h actual %h", $time, e.lo, rsp_cipher_low);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      block_type  b;
      logic [1:0] lens[8];
      lens = '{aesbe_pkg::KEY_LEN_128, aesbe_pkg::KEY_LEN_128, aesbe_pkg::KEY_LEN_192,
               aesbe_pkg::KEY_LEN_256, aesbe_pkg::KEY_LEN_RSV, aesbe_pkg::KEY_LEN_128,
               aesbe_pkg::KEY_LEN_256, aesbe_pkg::KEY_LEN_192};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) begin
            // reset key: edge patterns of the plaintext
            b = '{64'h0, 64'h0};                               plain_q.push_back(b);
            b = '{'1, '1};                                     plain_q.push_back(b);
            b = '{64'h0011223344556677, 64'h8899aabbccddeeff}; plain_q.push_back(b);
            b = '{{8{8'haa}}, {8{8'h55}}};                     plain_q.push_back(b);
            b = '{{8{8'h80}}, {8{8'h01}}};                     plain_q.push_back(b);
            for (int k = 0; k < 128; k += 17) begin
               b = '{64'h1 << (k % 64), '1 ^ (64'h1 << ((k + 9) % 64))};
               plain_q.push_back(b);
            end
         end else begin
            // new key setting, with a stray write to an unused index
            csr_write(aesbe_pkg::CSR_KEY_WORD_3 + 3'd1 + 3'($urandom_range(0, 2)),
                      {$urandom, $urandom});
            csr_write(aesbe_pkg::CSR_KEY_LENGTH, {62'($urandom), lens[ph]});
            csr_write(aesbe_pkg::CSR_KEY_WORD_0, (ph == 5 || ph == 6) ? '1 : rnd64());
            csr_write(aesbe_pkg::CSR_KEY_WORD_1, (ph == 5 || ph == 6) ? '1 : rnd64());
            csr_write(aesbe_pkg::CSR_KEY_WORD_2, (ph == 5 || ph == 6) ? '1 : rnd64());
            csr_write(aesbe_pkg::CSR_KEY_WORD_3, (ph == 5) ? '0 : rnd64());
         end
         quiet = (ph == 7);
         for (int n = 0; n < 130; n++) begin
            b = '{rnd64(), rnd64()};
            plain_q.push_back(b);
         end
         while (plain_q.size() > 0 || req_valid || cipher_q.size() > 0) @(posedge clock);
         repeat (30) @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
